// ----- hdl/tps_pkg.sv -----
// Shared types and constants for the timer prescaler/period search block.
// Used by tps_div and timer_prescaler_period_search_core; no dependencies.
package tps_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned OUT_W  = 16;
    localparam logic [DATA_W-1:0] CLK_RESET_HZ = 32'd72000000;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ----- hdl/tps_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle, 32-bit operands.
// Depends on tps_pkg for the request/response structs.
module tps_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tps_pkg::t_div_req i_req,
    output tps_pkg::t_div_rsp o_rsp
);

    localparam int unsigned W     = tps_pkg::DATA_W;
    localparam int unsigned CNT_W = $clog2(W);

    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [W:0] w_shift;
    logic [W:0] w_diff;
    logic       w_fit;

    assign w_shift = {r_rem, r_quo[W-1]};
    assign w_diff  = w_shift - {1'b0, r_div};
    assign w_fit   = (w_shift >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
            r_cnt <= CNT_W'(W - 1);
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[W-1:0] : w_shift[W-1:0];
            r_quo <= {r_quo[W-2:0], w_fit};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ----- hdl/timer_prescaler_period_search_core.sv -----
// Top level of the timer prescaler/period search: sequencer, best-pair tracking, stream ports.
// Depends on tps_pkg and tps_div.
//
// Takes a requested frequency and walks prescaler values upward from 0, using one shared
// bit-serial divider for both the period quotient and the achieved frequency, keeping the
// pair with the smallest error. One prescaler trial runs the period division, then the
// achieved-frequency division, with sequencing states between; a trial whose period is out
// of range skips the second division. The search ends at the first exact match, when the
// period would drop below 1, or after 2^COUNTER_BITS trials. A zero request goes straight
// to S_FIN, waits there until the output register is free and is then registered there,
// with bad_request set. The input is taken only while no search runs; a finished result may
// wait in the output register while the next request is taken. The user must write the clock
// register through the configuration port only while the block is idle; it is not enforced.
module timer_prescaler_period_search_core #(
    parameter int unsigned COUNTER_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata,     // timer_clock_hz
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,    // [31:0] requested frequency (Hz)
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,    // [15:0] prescaler, [31:16] period,
                                          // [63:32] achieved frequency, [95:64] freq_error_hz
    output logic [1:0]   m_axis_tuser     // [0] found, [1] bad_request
);

    localparam int unsigned W  = tps_pkg::DATA_W;
    localparam int unsigned CB = COUNTER_BITS;
    localparam logic [W:0]  MAXV = (33'd1 << CB) - 33'd1;
    localparam logic [CB-1:0] MAXP = MAXV[CB-1:0];

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_PREP   = 9'b000000010,
        S_DIVQ   = 9'b000000100,
        S_CHK    = 9'b000001000,
        S_MUL    = 9'b000010000,
        S_ASTART = 9'b000100000,
        S_DIVA   = 9'b001000000,
        S_CMP    = 9'b010000000,
        S_FIN    = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [W-1:0]  r_clk_hz;
    logic [W-1:0]  r_freq;
    logic [W:0]    r_d;        // (p+1) * freq, grows by freq each trial
    logic [CB-1:0] r_p;
    logic [CB-1:0] r_per;
    logic [W-1:0]  r_prod;
    logic [CB-1:0] r_best_p;
    logic [CB-1:0] r_best_per;
    logic [W-1:0]  r_best_act;
    logic [W-1:0]  r_best_err;
    logic          r_found;
    logic          r_bad;
    logic          r_m_valid;
    logic [95:0]   r_m_data;
    logic [1:0]    r_m_user;

    tps_pkg::t_div_req w_div_req;
    tps_pkg::t_div_rsp w_div_rsp;

    logic          w_s_acc;
    logic          w_last;
    logic          w_q_small;
    logic          w_per_big;
    logic [W:0]    w_per;
    logic [W:0]    w_p1;
    logic [W-1:0]  w_mul;
    logic [W-1:0]  w_err;
    logic          w_better;
    logic          w_out_free;

    tps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_s_acc    = s_axis_tvalid && s_axis_tready;
    assign w_last     = (r_p == MAXP);
    assign w_q_small  = (w_div_rsp.quotient < 32'd2);
    assign w_per      = {1'b0, w_div_rsp.quotient} - 33'd1;
    assign w_per_big  = (w_per > MAXV);
    assign w_p1       = {{(W + 1 - CB){1'b0}}, r_p} + 33'd1;
    // (p+1)*q never exceeds the clock value whenever q >= 2, so 32 bits hold it
    assign w_mul      = w_p1[W-1:0] * w_div_rsp.quotient;
    assign w_err      = (w_div_rsp.quotient > r_freq) ? (w_div_rsp.quotient - r_freq)
                                                      : (r_freq - w_div_rsp.quotient);
    assign w_better   = (w_err < r_best_err);
    assign w_out_free = !r_m_valid || m_axis_tready;

    assign w_div_req.start    = ((r_state == S_PREP) && (r_d <= {1'b0, r_clk_hz}))
                              || (r_state == S_ASTART);
    assign w_div_req.dividend = r_clk_hz;
    assign w_div_req.divisor  = (r_state == S_ASTART) ? r_prod : r_d[W-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_s_acc) begin
                    n_state = (s_axis_tdata == '0) ? S_FIN : S_PREP;
                end
            end
            S_PREP: begin
                // divisor above the clock means quotient zero: search is over
                n_state = (r_d <= {1'b0, r_clk_hz}) ? S_DIVQ : S_FIN;
            end
            S_DIVQ: begin
                if (w_div_rsp.done) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (w_q_small) begin
                    n_state = S_FIN;
                end else if (w_per_big) begin
                    n_state = w_last ? S_FIN : S_PREP;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL:    n_state = S_ASTART;
            S_ASTART: n_state = S_DIVA;
            S_DIVA: begin
                if (w_div_rsp.done) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if ((w_better && w_err == '0) || w_last) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_PREP;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_clk_hz  <= tps_pkg::CLK_RESET_HZ;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_clk_hz <= i_cfg_wdata;
            end
            if (r_state == S_FIN && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_s_acc) begin
                    r_freq     <= s_axis_tdata;
                    r_d        <= {1'b0, s_axis_tdata};
                    r_p        <= '0;
                    r_best_p   <= '0;
                    r_best_per <= '0;
                    r_best_act <= '0;
                    r_best_err <= '1;
                    r_found    <= 1'b0;
                    r_bad      <= (s_axis_tdata == '0);
                end
            end
            S_CHK: begin
                r_per <= w_per[CB-1:0];
                if (!w_q_small && w_per_big && !w_last) begin
                    r_p <= r_p + 1'b1;
                    r_d <= r_d + {1'b0, r_freq};
                end
            end
            S_MUL: begin
                r_prod <= w_mul;
            end
            S_CMP: begin
                if (w_better) begin
                    r_best_p   <= r_p;
                    r_best_per <= r_per;
                    r_best_act <= w_div_rsp.quotient;
                    r_best_err <= w_err;
                    r_found    <= 1'b1;
                end
                if (!w_last) begin
                    r_p <= r_p + 1'b1;
                    r_d <= r_d + {1'b0, r_freq};
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    if (r_bad) begin
                        r_m_data <= '0;
                        r_m_user <= 2'b10;
                    end else begin
                        r_m_data <= {r_best_err,
                                     r_found ? r_best_act : r_clk_hz,
                                     tps_pkg::OUT_W'(r_best_per),
                                     tps_pkg::OUT_W'(r_best_p)};
                        r_m_user <= {1'b0, r_found};
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

`ifndef SYNTHESIS
    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_DIVQ || r_state == S_DIVA))
        else $error("divider finished outside a wait state");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("found and bad_request both set");

    a_not_found_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == 2'b00) |-> (m_axis_tdata[95:64] == '1))
        else $error("no pair found but error is not all ones");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |=> !s_axis_tready)
        else $error("input ready while a division runs");
`endif

endmodule
